[sv/batch_norm_inference_top_defines.svh]
// Assertion macros shared by the batch normalisation modules.
`ifndef BATCH_NORM_INFERENCE_TOP_DEFINES_SVH
`define BATCH_NORM_INFERENCE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BN_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define BN_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`else
`define BN_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BN_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

[sv/bnorm_pkg.sv]
// Shared constants, codes and item type of the batch normalisation block.
`timescale 1ns / 1ps
package bnorm_pkg;
   localparam int MAX_CHANNELS_DEF = 256;
   localparam int MAX_PLANE_DEF    = 1048576;
   localparam int QUEUE_DEPTH      = 4;
   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 21;
   localparam int VSUM_W           = 25;
   localparam int DIV_STEPS        = 65;
   localparam int SQRT_STEPS       = 33;
   localparam int STEP_W           = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_EPSILON      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_CHANNELS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLANE_SIZE   = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic                     plane_end;
      logic signed [15:0]       sample;
      logic signed [15:0]       scale;
      logic signed [15:0]       bias;
      logic signed [15:0]       mean;
      logic        [VSUM_W-1:0] var_sum;
   } bnorm_item_type;
endpackage

[sv/batch_norm_inference_top.sv]
// Top level of the fixed-point inference batch normalisation block.
`timescale 1ns / 1ps
// Usage: words arrive on the req_ channel. A load word (tuser 0) stores one
// channel's bias, mean and the gain scale/sqrt(variance+epsilon); it gives no
// result. A data word (tuser 1) carries one Q8.8 sample of an NCHW stream; the
// plane and channel counters pick its channel, and one result word leaves on
// the rsp_ channel with the saturated Q8.8 value, its channel, a clip flag in
// tuser and tlast on the last sample of a channel plane.
// The back end takes one data word at a time through table read, multiply,
// and round and saturate, waiting in the last while the receiver stalls; a
// load word occupies the iterative gain unit for the square, 65 restoring
// divide steps and 33 square-root steps. A four-word queue lets the front
// keep accepting while the back end is busy.
// A data word passes the queue, the table read, product and result registers.
// Reset clears the counters, the queue and the result valid flag and sets the
// registers to epsilon 1, one channel and a plane of one; the channel table
// holds nothing until loaded. When the receiver stalls, the result register
// holds its word and the queue fills until req_tready drops.
module batch_norm_inference_top import bnorm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_PLANE    = MAX_PLANE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // channel_index, scale_value, bias_value, mean_value, variance_value, sample
   input  logic [95:0]           req_tdata,
   // req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // normalized, out_channel
   output logic [23:0]           rsp_tdata,
   // clipped
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ENTRY_W = $bits(bnorm_item_type) + CH_W;

   logic               push, queue_full, queue_empty, queue_pop;
   bnorm_item_type     push_item, head_item;
   logic [CH_W-1:0]    push_channel, head_channel;
   logic [ENTRY_W-1:0] head_entry;

   bnorm_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_PLANE    (MAX_PLANE),
      .CH_W         (CH_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .push         (push),
      .push_item    (push_item),
      .push_channel (push_channel),
      .queue_full   (queue_full)
   );

   bnorm_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_channel, push_item}),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (head_entry),
      .empty     (queue_empty)
   );

   assign head_item    = head_entry[$bits(bnorm_item_type)-1:0];
   assign head_channel = head_entry[ENTRY_W-1:$bits(bnorm_item_type)];

   bnorm_back #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .CH_W         (CH_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .queue_pop    (queue_pop),
      .head_item    (head_item),
      .head_channel (head_channel),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );
endmodule

[sv/bnorm_gain.sv]
// Iterative gain unit: rounded scale * 2^16 / sqrt(variance sum).
`timescale 1ns / 1ps
`include "batch_norm_inference_top_defines.svh"
module bnorm_gain import bnorm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [15:0]       scale,
   input  logic        [VSUM_W-1:0] var_sum,
   output logic                     done,
   output logic        [31:0]       gain
);
   localparam logic [2:0] G_IDLE   = 3'd0;
   localparam logic [2:0] G_SQUARE = 3'd1;
   localparam logic [2:0] G_DIV    = 3'd2;
   localparam logic [2:0] G_SQRT   = 3'd3;
   localparam logic [2:0] G_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [15:0]       mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [VSUM_W-1:0] div_ff, div_in;
   logic [65:0]       work_ff, work_in;
   logic [35:0]       rem_ff, rem_in;
   logic [32:0]       root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [16:0] sx, mag17;
   logic [31:0] sq;
   logic [25:0] dsh, dsub;
   logic        dge;
   logic [35:0] ssh, trial;
   logic        sge;
   logic [33:0] rnd;
   logic [31:0] q;

   assign sx    = {scale[15], scale};
   assign mag17 = scale[15] ? (~sx + 17'd1) : sx;
   assign sq    = {16'd0, mag_ff} * {16'd0, mag_ff};
   assign dsh   = {rem_ff[24:0], work_ff[64]};
   assign dsub  = dsh - {1'b0, div_ff};
   assign dge   = dsh >= {1'b0, div_ff};
   assign ssh   = {rem_ff[33:0], work_ff[65:64]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign sge   = ssh >= trial;
   // Halve the doubled root with rounding, then restore the sign.
   assign rnd   = {1'b0, root_ff} + 34'd1;
   assign q     = rnd[32:1];
   assign gain  = neg_ff ? (32'd0 - q) : q;
   assign done  = state_ff == G_DONE;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               mag_in   = mag17[15:0];
               neg_in   = scale[15];
               div_in   = var_sum;
               state_in = G_SQUARE;
            end
         end
         G_SQUARE: begin
            work_in  = {1'b0, sq[30:0], 34'd0};
            rem_in   = '0;
            step_in  = '0;
            state_in = G_DIV;
         end
         G_DIV: begin
            rem_in  = {10'd0, dge ? dsub : dsh};
            work_in = {1'b0, work_ff[63:0], dge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = G_SQRT;
            end
         end
         G_SQRT: begin
            rem_in  = sge ? (ssh - trial) : ssh;
            root_in = {root_ff[31:0], sge};
            work_in = {work_ff[63:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = G_DONE;
            end
         end
         G_DONE: begin
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   `BN_ASSERT_IMPLY(a_gain_start_idle, start, state_ff == G_IDLE, "gain unit started while busy")
endmodule

[sv/bnorm_fifo.sv]
// Short item queue between the front and back parts.
`timescale 1ns / 1ps
`include "batch_norm_inference_top_defines.svh"
module bnorm_fifo import bnorm_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BN_ASSERT_ALWAYS(a_fifo_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `BN_ASSERT_IMPLY(a_fifo_push_room, push, !full || pop, "push into full queue")
endmodule

[sv/bnorm_front.sv]
// Front part: configuration registers, input acceptance and channel tracking.
`timescale 1ns / 1ps
module bnorm_front import bnorm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_PLANE    = MAX_PLANE_DEF,
   parameter int CH_W         = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,
   input  logic                  req_tuser,
   output logic                  push,
   output bnorm_item_type        push_item,
   output logic [CH_W-1:0]       push_channel,
   input  logic                  queue_full
);
   localparam int POS_W = (MAX_PLANE > 1) ? $clog2(MAX_PLANE) : 1;

   logic [15:0]      eps_ff, eps_in;
   logic [8:0]       nch_ff, nch_in;
   logic [20:0]      psz_ff, psz_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic        accept, is_data, load_ok, last, wrap;
   logic [7:0]  f_idx;
   logic [23:0] f_var;
   logic [31:0] nc_eff, ps_eff;
   logic [VSUM_W-1:0] vsum;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_data    = req_tuser == REQ_DATA;
   assign f_idx      = req_tdata[7:0];
   assign f_var      = req_tdata[79:56];
   assign load_ok    = {24'd0, f_idx} < 32'(MAX_CHANNELS);

   always_comb begin
      nc_eff = (nch_ff == '0) ? 32'd1 : {23'd0, nch_ff};
      if (nc_eff > 32'(MAX_CHANNELS)) begin
         nc_eff = 32'(MAX_CHANNELS);
      end
      ps_eff = (psz_ff == '0) ? 32'd1 : {11'd0, psz_ff};
      if (ps_eff > 32'(MAX_PLANE)) begin
         ps_eff = 32'(MAX_PLANE);
      end
      vsum = {1'b0, f_var} + {9'd0, eps_ff};
      if (vsum == '0) begin
         vsum = VSUM_W'(1);
      end
   end

   assign last = (32'(pos_ff) + 32'd1) >= ps_eff;
   assign wrap = (32'(ch_ff) + 32'd1) >= nc_eff;

   assign push                = accept && (is_data || load_ok);
   assign push_channel        = is_data ? ch_ff : CH_W'(f_idx);
   assign push_item.kind      = req_tuser;
   assign push_item.plane_end = last;
   assign push_item.scale     = req_tdata[23:8];
   assign push_item.bias      = req_tdata[39:24];
   assign push_item.mean      = req_tdata[55:40];
   assign push_item.sample    = req_tdata[95:80];
   assign push_item.var_sum   = vsum;

   always_comb begin
      eps_in = eps_ff;
      nch_in = nch_ff;
      psz_in = psz_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_EPSILON:      eps_in = csr_wdata[15:0];
            CSR_NUM_CHANNELS: nch_in = csr_wdata[8:0];
            CSR_PLANE_SIZE:   psz_in = csr_wdata;
            default:          eps_in = eps_ff;
         endcase
      end
      ch_in  = ch_ff;
      pos_in = pos_ff;
      if (accept && is_data) begin
         if (last) begin
            pos_in = '0;
            ch_in  = wrap ? '0 : ch_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 16'd1;
         nch_ff <= 9'd1;
         psz_ff <= 21'd1;
         ch_ff  <= '0;
         pos_ff <= '0;
      end else begin
         eps_ff <= eps_in;
         nch_ff <= nch_in;
         psz_ff <= psz_in;
         ch_ff  <= ch_in;
         pos_ff <= pos_in;
      end
   end
endmodule

[sv/bnorm_back.sv]
// Back part: channel table, gain computation and the normalising datapath.
`timescale 1ns / 1ps
`include "batch_norm_inference_top_defines.svh"
module bnorm_back import bnorm_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int CH_W         = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   output logic            queue_pop,
   input  bnorm_item_type  head_item,
   input  logic [CH_W-1:0] head_channel,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,
   output logic            rsp_tuser,
   output logic            rsp_tlast
);
   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_MUL   = 2'd1;
   localparam logic [1:0] B_ROUND = 2'd2;
   localparam logic [1:0] B_LOAD  = 2'd3;

   logic [1:0]         state_ff, state_in;
   bnorm_item_type     cur_ff, cur_in;
   logic [CH_W-1:0]    cur_ch_ff, cur_ch_in;
   logic [63:0]        table_mem [MAX_CHANNELS];
   logic [63:0]        rd_ff;
   logic signed [48:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               gain_start_ff, gain_start_in;
   logic [15:0]        norm_ff, norm_in;
   logic [7:0]         och_ff, och_in;
   logic               clip_ff, clip_in;
   logic               end_ff, end_in;

   logic               rd_en, wr_en, gain_start, gain_done, out_load;
   logic [31:0]        gain;
   logic signed [31:0] g_s;
   logic signed [16:0] diff;
   logic signed [49:0] acc;
   logic signed [33:0] r;

   bnorm_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .start   (gain_start),
      .scale   (cur_ff.scale),
      .var_sum (cur_ff.var_sum),
      .done    (gain_done),
      .gain    (gain)
   );

   assign queue_pop     = (state_ff == B_IDLE) && !queue_empty;
   assign rd_en         = queue_pop && (head_item.kind == REQ_DATA);
   assign wr_en         = (state_ff == B_LOAD) && gain_done;
   // The gain unit is started the cycle after the load is popped.
   assign gain_start_in = queue_pop && (head_item.kind == REQ_LOAD);
   assign gain_start    = gain_start_ff;
   assign out_load      = (state_ff == B_ROUND) && (!rsp_valid_ff || rsp_tready);

   assign g_s     = $signed(rd_ff[63:32]);
   assign diff    = $signed({cur_ff.sample[15], cur_ff.sample})
                  - $signed({rd_ff[31], rd_ff[31:16]});
   assign prod_in = g_s * diff;
   assign acc     = {prod_ff[48], prod_ff} + {{18{rd_ff[15]}}, rd_ff[15:0], 16'd0}
                  + 50'sd32768;
   assign r       = acc[49:16];

   always_comb begin
      clip_in = 1'b0;
      norm_in = r[15:0];
      if (r > 34'sd32767) begin
         norm_in = 16'h7fff;
         clip_in = 1'b1;
      end else if (r < -34'sd32768) begin
         norm_in = 16'h8000;
         clip_in = 1'b1;
      end
      och_in = 8'(cur_ch_ff);
      end_in = cur_ff.plane_end;
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      cur_ch_in = cur_ch_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               cur_in    = head_item;
               cur_ch_in = head_channel;
               state_in  = (head_item.kind == REQ_DATA) ? B_MUL : B_LOAD;
            end
         end
         B_MUL:   state_in = B_ROUND;
         B_ROUND: state_in = out_load ? B_IDLE : B_ROUND;
         B_LOAD:  state_in = gain_done ? B_IDLE : B_LOAD;
         default: state_in = B_IDLE;
      endcase
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rsp_valid_ff  <= 1'b0;
         gain_start_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         gain_start_ff <= gain_start_in;
      end
      cur_ff    <= cur_in;
      cur_ch_ff <= cur_ch_in;
      prod_ff   <= prod_in;
      if (out_load) begin
         norm_ff <= norm_in;
         och_ff  <= och_in;
         clip_ff <= clip_in;
         end_ff  <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= table_mem[head_channel];
      end
      if (wr_en) begin
         table_mem[cur_ch_ff] <= {gain, cur_ff.mean, cur_ff.bias};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {och_ff, norm_ff};
   assign rsp_tuser  = clip_ff;
   assign rsp_tlast  = end_ff;

   `BN_ASSERT_IMPLY(a_back_out_data, out_load, cur_ff.kind == REQ_DATA, "result from a load item")
   `BN_ASSERT_IMPLY(a_back_gain_done, gain_done, state_ff == B_LOAD, "stray gain completion")
endmodule

[verif/batch_norm_inference_top_test.sv]
// Self-checking stream testbench for the fixed-point batch normalisation block.
`timescale 1ns / 1ps
module batch_norm_inference_top_test;
   import bnorm_pkg::*;

   // One request word as the sender sees it, before packing.
   typedef struct {
      logic               kind;
      logic [7:0]         channel;
      logic signed [15:0] scale;
      logic signed [15:0] bias;
      logic signed [15:0] mean;
      logic [23:0]        variance;
      logic signed [15:0] sample;
   } bn_request_type;

   // One normalised result word.
   typedef struct {
      logic signed [15:0] value;
      logic [7:0]         channel;
      logic               clipped;
      logic               last;
   } bn_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [95:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   batch_norm_inference_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Requests waiting to be sent, and results predicted but not yet seen.
   bn_request_type pending_requests[$];
   bn_result_type  expected_results[$];
   int             error_count = 0;
   // When set, neither side idles; this gives stretches at full rate.
   bit             full_rate = 1'b0;

   // Shadow copy of the block's state, updated as words are accepted.
   logic signed [31:0] gain_mem[256];
   logic signed [15:0] mean_mem[256];
   logic signed [15:0] bias_mem[256];
   int unsigned        plane_pos = 0;
   int unsigned        chan_pos = 0;
   int unsigned        eps_reg = 1;
   int unsigned        channels_reg = 1;
   int unsigned        plane_reg = 1;
   // Channels that the generator has already loaded, so no unloaded entry is read.
   bit                 channel_loaded[256];

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (n >= res + bit_val) begin
            n = n - (res + bit_val);
            res = (res >> 1) + bit_val;
         end else begin
            res = res >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return res;
   endfunction

   // Gain = scale / sqrt(variance + epsilon) as signed Q16.16, ties away from zero.
   function automatic logic signed [31:0] channel_gain(logic signed [15:0] scale,
                                                      longint unsigned vsum);
      longint unsigned mag, num, q1, r1, root, q;
      longint          signed_q;
      mag = (scale < 0) ? longint'(-longint'(scale)) : longint'(scale);
      if (vsum == 0) vsum = 1;
      num = (mag * mag) << 32;
      q1 = num / vsum;
      r1 = num % vsum;
      if (q1 >= (64'd1 << 62)) root = 64'd1 << 32;
      else root = int_sqrt(4 * q1 + (4 * r1) / vsum);
      q = (root + 1) >> 1;
      signed_q = (scale < 0) ? -longint'(q) : longint'(q);
      return signed_q[31:0];
   endfunction

   // Applies one accepted request word to the shadow state and queues any result.
   function automatic void normalise_word(bn_request_type w);
      longint        acc, rounded;
      int unsigned   nc, ps, ch;
      bn_result_type r;
      if (w.kind == REQ_LOAD) begin
         gain_mem[w.channel] = channel_gain(w.scale, longint'(w.variance) + eps_reg);
         bias_mem[w.channel] = w.bias;
         mean_mem[w.channel] = w.mean;
         return;
      end
      ch = chan_pos;
      acc = longint'(gain_mem[ch]) * (longint'(w.sample) - longint'(mean_mem[ch]))
            + longint'(bias_mem[ch]) * 65536;
      rounded = (acc + 32768) >>> 16;
      r.clipped = 1'b0;
      if (rounded > 32767) begin
         rounded = 32767;
         r.clipped = 1'b1;
      end else if (rounded < -32768) begin
         rounded = -32768;
         r.clipped = 1'b1;
      end
      r.value = rounded[15:0];
      r.channel = ch[7:0];
      nc = (channels_reg == 0) ? 1 : (channels_reg > 256 ? 256 : channels_reg);
      ps = (plane_reg == 0) ? 1 : (plane_reg > 1048576 ? 1048576 : plane_reg);
      r.last = (plane_pos + 1 >= ps);
      if (r.last) begin
         plane_pos = 0;
         chan_pos = (ch + 1 >= nc) ? 0 : ch + 1;
      end else begin
         plane_pos++;
      end
      expected_results.push_back(r);
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (full_rate || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sender: predicts each word as it is taken, then offers the next one.
   bn_request_type on_bus;
   int             send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) normalise_word(on_bus);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               on_bus = pending_requests.pop_front();
               req_tdata <= {on_bus.sample, on_bus.variance, on_bus.mean, on_bus.bias,
                             on_bus.scale, on_bus.channel};
               req_tuser <= on_bus.kind;
               req_tvalid <= 1'b1;
               send_gap = idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word against the oldest prediction, with
   // random back-pressure.
   int stall_left = 0;
   always @(posedge clock) begin
      bn_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result word with no prediction: tdata=%h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[15:0] !== want.value) begin
                  $error("normalized: expected %0d, got %0d", want.value,
                         $signed(rsp_tdata[15:0]));
                  error_count++;
               end
               if (rsp_tdata[23:16] !== want.channel) begin
                  $error("out_channel: expected %0d, got %0d", want.channel,
                         rsp_tdata[23:16]);
                  error_count++;
               end
               if (rsp_tuser !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("plane_end: expected %0b, got %0b", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!full_rate && $urandom_range(0, 5) == 0) stall_left = idle_length();
         end
      end
   end

   function automatic bn_request_type random_word(logic kind);
      bn_request_type w;
      w.kind = kind;
      w.channel = $urandom_range(0, 255);
      w.scale = $urandom;
      w.bias = $urandom;
      w.mean = $urandom;
      // Small variances give large gains and hence saturation.
      w.variance = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom;
      w.sample = $urandom;
      if ($urandom_range(0, 9) == 0) w.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      return w;
   endfunction

   task automatic queue_load(logic [7:0] ch, logic signed [15:0] scale,
                             logic signed [15:0] bias, logic signed [15:0] mean,
                             logic [23:0] variance);
      bn_request_type w;
      w = random_word(REQ_LOAD);
      w.channel = ch;
      w.scale = scale;
      w.bias = bias;
      w.mean = mean;
      w.variance = variance;
      channel_loaded[ch] = 1'b1;
      pending_requests.push_back(w);
   endtask

   task automatic queue_sample(logic signed [15:0] sample);
      bn_request_type w;
      w = random_word(REQ_DATA);
      w.sample = sample;
      pending_requests.push_back(w);
   endtask

   // Waits until everything sent has been answered, then lets a load that
   // gives no result run out of the gain unit before any register changes.
   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_EPSILON) eps_reg = value & 32'hffff;
      else if (addr == CSR_NUM_CHANNELS) channels_reg = value & 32'h1ff;
      else plane_reg = value & 32'h1fffff;
   endtask

   // One configuration phase: load each channel in use that is not yet loaded,
   // and some again at random, then a random mix of mostly samples with the odd reload.
   task automatic run_phase(int unsigned eps, int unsigned nc, int unsigned ps,
                            int count);
      int unsigned used;
      drain();
      write_reg(CSR_EPSILON, eps);
      write_reg(CSR_NUM_CHANNELS, nc);
      write_reg(CSR_PLANE_SIZE, ps);
      full_rate = ($urandom_range(0, 3) == 0);
      used = (nc == 0) ? 1 : (nc > 256 ? 256 : nc);
      for (int c = 0; c < used; c++)
         if (!channel_loaded[c] || $urandom_range(0, 3) == 0)
            queue_load(c, $urandom, $urandom, $urandom, $urandom);
      for (int i = 0; i < count; i++) begin
         bn_request_type w;
         w = random_word(($urandom_range(0, 99) < 85) ? REQ_DATA : REQ_LOAD);
         if (w.kind == REQ_LOAD) channel_loaded[w.channel] = 1'b1;
         pending_requests.push_back(w);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings (one channel, plane of one, epsilon 1):
      // field extremes, zero scale and maximum variance.
      queue_load(8'd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 24'd0);
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      queue_load(8'd0, 16'sh8000, 16'sh8000, 16'sh7fff, 24'hffffff);
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      queue_sample(16'sh0000);
      queue_load(8'd0, 16'sh0000, 16'sh0100, 16'sh0000, 24'h010000);
      queue_sample(16'shffff);
      queue_load(8'd255, 16'sh0100, 16'sh0000, 16'sh0000, 24'h010000);
      drain();

      // Zero epsilon with zero variance: the sum is taken as one, and the
      // most negative scale gives the largest possible gain.
      write_reg(CSR_EPSILON, 0);
      queue_load(8'd0, 16'sh8000, 16'sh0000, 16'sh0000, 24'd0);
      queue_sample(16'sh0001);
      queue_sample(16'shffff);
      queue_sample(16'sh0000);
      queue_load(8'd0, 16'sh7fff, 16'sh8000, 16'sh0000, 24'd0);
      queue_sample(16'sh0000);
      queue_sample(16'sh7fff);

      // Random phases; zero counts act as one, oversized counts are clamped,
      // and counters left past a new limit are carried across the writes.
      run_phase(65535, 4, 3, 200);
      run_phase(0, 0, 0, 120);
      run_phase(1, 511, 2, 120);
      run_phase(300, 3, 5, 150);
      run_phase(7, 2, 2097151, 100);
      run_phase(1, 1, 1, 120);
      run_phase($urandom_range(0, 65535), 256, 1, 150);
      run_phase($urandom_range(0, 65535), 5, 4, 150);
      run_phase(2, $urandom_range(1, 8), $urandom_range(1, 6), 200);
      drain();

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
